// File: src/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg
// shared types and codes for the bounded sequence table and its entry cells
// ----------------------------------------------------------------------------
package bst_pkg;

  // action codes of an input transaction
  localparam logic [2:0] ACT_PUSH   = 3'd0;
  localparam logic [2:0] ACT_POP    = 3'd1;
  localparam logic [2:0] ACT_INSERT = 3'd2;
  localparam logic [2:0] ACT_REMOVE = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;
  localparam logic [2:0] ACT_CLEAR  = 3'd5;

  // status codes of a result transaction
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADIDX = 2'd3;

  // cell operation codes
  localparam logic [2:0] OP_HOLD   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_ZERO   = 3'd2;
  localparam logic [2:0] OP_INSERT = 3'd3;
  localparam logic [2:0] OP_REMOVE = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  // configuration register indexes
  localparam logic REG_CAPACITY = 1'b0;

  localparam int unsigned LEN_W  = 7;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned WORD_W = 32;
  localparam logic [LEN_W-1:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic [2:0]        action;
    logic [IDX_W-1:0]  index;
    logic [WORD_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [WORD_W-1:0] read_value;
    logic [LEN_W-1:0]  list_length;
  } out_t;

  // broadcast command from the controller to every cell
  typedef struct packed {
    logic [2:0]       op;
    logic [LEN_W-1:0] pos;
    logic             rd_load;
    logic             rd_shift;
  } cmd_t;

endpackage

// File: src/bst_cell.sv
// ----------------------------------------------------------------------------
// bst_cell
// one list entry plus one stage of the read-out shift chain
// ----------------------------------------------------------------------------
module bst_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned POS        = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bst_pkg::cmd_t         cmd,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic [DATA_WIDTH-1:0] right_rd,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] rd
);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic [DATA_WIDTH-1:0] rd_r, rd_nxt;
  logic                  hit, above;

  assign hit   = (32'(cmd.pos) == POS);
  assign above = (32'(cmd.pos) < POS);

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      bst_pkg::OP_HOLD: data_nxt = data_r;
      bst_pkg::OP_WRITE: begin
        if (hit) data_nxt = word;
      end
      bst_pkg::OP_ZERO: begin
        if (hit) data_nxt = '0;
      end
      // entries at and above pos move one place up
      bst_pkg::OP_INSERT: begin
        if (hit) data_nxt = word;
        else if (above) data_nxt = left_data;
      end
      // entries above pos move one place down, zeros come in from the top
      bst_pkg::OP_REMOVE: begin
        if (hit || above) data_nxt = right_data;
      end
      bst_pkg::OP_CLEAR: data_nxt = '0;
      default: data_nxt = data_r;
    endcase
  end

  always_comb begin
    rd_nxt = rd_r;
    if (cmd.rd_load) rd_nxt = data_r;
    else if (cmd.rd_shift) rd_nxt = right_rd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= rd_nxt;
  end

  assign data = data_r;
  assign rd   = rd_r;

endmodule

// File: src/bounded_sequence_table.sv
// ----------------------------------------------------------------------------
// bounded_sequence_table
// fixed-capacity ordered list of words held in a chain of entry cells
// ----------------------------------------------------------------------------
//
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+---------------------------
//  input    | start, busy, in_item                   | taken when start & !busy
//  result   | out_valid, out_item                    | one-cycle strobe, no stall
//  config   | psel, penable, pwrite, paddr, pwdata,  | apb write in access phase,
//           | prdata, pready                         | pready tied high
//
//  push, pop, insert, remove, clear, a failed read and unused action codes
//  finish at the accepting edge: the result shows in the next cycle and a new
//  transaction can be taken in that same cycle (one transaction per cycle)
//  a good read snapshots every cell into the read chain and shifts it toward
//  cell 0 once per cycle, index shifts in all; busy stays high until the entry
//  reaches cell 0 and the result shows in the same cycle that busy falls
//  synchronous active-low reset clears every cell, the length and sets the
//  capacity register to 64; no clearing pass is needed
//  the receiver cannot stall results
//
module bounded_sequence_table #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                start,
  output logic                busy,
  input  bst_pkg::in_t        in_item,
  // result channel
  output logic                out_valid,
  output bst_pkg::out_t       out_item,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned LEN_W = bst_pkg::LEN_W;
  localparam int unsigned IDX_W = bst_pkg::IDX_W;

  // control state
  logic               busy_r, busy_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [LEN_W-1:0]   used_r, used_nxt;
  logic [LEN_W-1:0]   cap_r;
  logic               out_valid_r, out_valid_nxt;
  bst_pkg::out_t      out_r, out_nxt;

  logic               accept;
  logic               cfg_wr;
  logic [LEN_W-1:0]   cap_eff;
  logic [LEN_W-1:0]   idx_ext;
  logic [DATA_WIDTH-1:0] word;
  bst_pkg::cmd_t      cmd;

  // cell chain wiring
  logic [DATA_WIDTH-1:0] data_w [DEPTH];
  logic [DATA_WIDTH-1:0] rd_w   [DEPTH];

  assign accept  = start && !busy_r;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign idx_ext = LEN_W'(in_item.index);
  assign word    = DATA_WIDTH'(in_item.value);

  // capacity never exceeds the built depth
  assign cap_eff = (32'(cap_r) > DEPTH) ? LEN_W'(DEPTH) : cap_r;

  // decode one transaction into a cell command and its result
  always_comb begin
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    used_nxt      = used_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    cmd.op        = bst_pkg::OP_HOLD;
    cmd.pos       = idx_ext;
    cmd.rd_load   = 1'b0;
    cmd.rd_shift  = 1'b0;

    if (busy_r) begin
      // read in flight: shift the chain until the entry reaches cell 0
      if (cnt_r != '0) begin
        cmd.rd_shift = 1'b1;
        cnt_nxt      = cnt_r - IDX_W'(1);
      end else begin
        busy_nxt               = 1'b0;
        out_valid_nxt          = 1'b1;
        out_nxt.status         = bst_pkg::ST_OK;
        out_nxt.read_value     = 32'(rd_w[0]);
        out_nxt.list_length    = used_r;
      end
    end else if (accept) begin
      out_nxt.status     = bst_pkg::ST_OK;
      out_nxt.read_value = '0;
      case (in_item.action)
        bst_pkg::ACT_PUSH: begin
          if (used_r >= cap_eff) begin
            out_nxt.status = bst_pkg::ST_FULL;
          end else begin
            cmd.op   = bst_pkg::OP_WRITE;
            cmd.pos  = used_r;
            used_nxt = used_r + LEN_W'(1);
          end
        end
        bst_pkg::ACT_POP: begin
          if (used_r == '0) begin
            out_nxt.status = bst_pkg::ST_EMPTY;
          end else begin
            cmd.op   = bst_pkg::OP_ZERO;
            cmd.pos  = used_r - LEN_W'(1);
            used_nxt = used_r - LEN_W'(1);
          end
        end
        bst_pkg::ACT_INSERT: begin
          if (idx_ext >= cap_eff || idx_ext > used_r) begin
            out_nxt.status = bst_pkg::ST_BADIDX;
          end else if (used_r >= cap_eff) begin
            out_nxt.status = bst_pkg::ST_FULL;
          end else begin
            cmd.op   = bst_pkg::OP_INSERT;
            used_nxt = used_r + LEN_W'(1);
          end
        end
        bst_pkg::ACT_REMOVE: begin
          if (used_r == '0) begin
            out_nxt.status = bst_pkg::ST_EMPTY;
          end else if (idx_ext >= used_r) begin
            out_nxt.status = bst_pkg::ST_BADIDX;
          end else begin
            cmd.op   = bst_pkg::OP_REMOVE;
            used_nxt = used_r - LEN_W'(1);
          end
        end
        bst_pkg::ACT_READ: begin
          if (idx_ext >= used_r) begin
            out_nxt.status = bst_pkg::ST_BADIDX;
          end else begin
            cmd.rd_load = 1'b1;
            busy_nxt    = 1'b1;
            cnt_nxt     = in_item.index;
          end
        end
        bst_pkg::ACT_CLEAR: begin
          cmd.op   = bst_pkg::OP_CLEAR;
          used_nxt = '0;
        end
        default: begin
          // unused action codes change nothing
        end
      endcase
      out_nxt.list_length = used_nxt;
      out_valid_nxt       = !cmd.rd_load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      used_r      <= '0;
      cap_r       <= bst_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && paddr[2] == bst_pkg::REG_CAPACITY) begin
        cap_r <= pwdata[LEN_W-1:0];
      end
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // the chain of entry cells; each takes its neighbors' words
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d, right_d, right_rd;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = data_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d  = '0;
      assign right_rd = '0;
    end else begin : g_right
      assign right_d  = data_w[i+1];
      assign right_rd = rd_w[i+1];
    end
    bst_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .POS        (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .word       (word),
      .left_data  (left_d),
      .right_data (right_d),
      .right_rd   (right_rd),
      .data       (data_w[i]),
      .rd         (rd_w[i])
    );
  end

  // outputs
  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == bst_pkg::REG_CAPACITY) ? 32'(cap_r) : '0;

endmodule

// File: src/bst_checker.sv
// ----------------------------------------------------------------------------
// bst_checker
// port-level checks on the bounded sequence table
// ----------------------------------------------------------------------------
module bst_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input bst_pkg::out_t out_item
);

  // a result never shows while a read is still in flight
  a_no_result_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && busy))
    else $error("result strobe while busy");

  // every accepted transaction either answers at once or starts a read
  a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("accepted transaction gave neither result nor busy");

  // a finishing read always delivers its result
  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("busy fell without a result");

  // empty status only on an empty list
  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == bst_pkg::ST_EMPTY |-> out_item.list_length == '0)
    else $error("empty status with nonzero length");

  // a nonzero read word only comes with ok status
  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.read_value != '0 |-> out_item.status == bst_pkg::ST_OK)
    else $error("read word on a failed transaction");

endmodule

bind bounded_sequence_table bst_checker u_bst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
